// ===== hdl/pair_key_relabeler_assert.svh =====
// Assertion macros for the pair key relabeler; clk and rst_n come from the using module.
`ifndef PAIR_KEY_RELABELER_ASSERT_SVH
`define PAIR_KEY_RELABELER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PKR_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pair_key_relabeler: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define PKR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pair_key_relabeler: next-cycle check failed");

`endif

// ===== hdl/pkr_pkg.sv =====
`default_nettype none

package pkr_pkg;

    localparam int BIN_FIELD_W   = 16;
    localparam int LABEL_FIELD_W = 8;

    // One pixel: a pair of bin numbers and the start-of-image mark.
    typedef struct packed {
        logic [BIN_FIELD_W-1:0] bin_a;
        logic [BIN_FIELD_W-1:0] bin_b;
        logic                   first_pixel;
    } pix_t;

    // One result: merged label and its flags.
    typedef struct packed {
        logic [LABEL_FIELD_W-1:0] new_label;
        logic                     is_new;
        logic                     overflow;
    } lbl_t;

    // Outcome of one table lookup.
    typedef struct packed {
        logic hit;
        logic fresh;
        logic full;
    } lookup_t;

endpackage

`default_nettype wire

// ===== hdl/pair_key_relabeler.sv =====
// pair_key_relabeler: merges two label maps into one by giving every distinct
// (bin_a, bin_b) pair its own label, in order of first appearance.
// Input channel px (px_valid/px_ready/px_data): one pixel per transfer.
//   Set first_pixel on the first pixel of an image to empty the table.
// Output channel lbl (lbl_valid/lbl_ready/lbl_data): one result per pixel,
//   in pixel order: the label, is_new on a first sighting, overflow when a
//   new pair finds all TABLE_DEPTH entries taken (label 0, nothing stored).
// Path: a transferred pixel sits in the input register for its lookup; its
//   result goes to the output register. Throughput: one pixel per cycle while
//   lbl_ready is high, by matching all entries and writing a new key at once.
// Stall: a result waits in the output register while lbl_ready is low; one
//   more pixel can sit in the input register, then px_ready drops.
// Reset: rst_n clears the entry valid bits, the label count and both stage
//   valids; the table is empty and usable in the first cycle after reset.
`default_nettype none
`include "pair_key_relabeler_assert.svh"

module pair_key_relabeler #(
    parameter int TABLE_DEPTH = 256,
    parameter int BIN_BITS    = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           px_valid,
    output logic           px_ready,
    input  pkr_pkg::pix_t  px_data,
    output logic           lbl_valid,
    input  logic           lbl_ready,
    output pkr_pkg::lbl_t  lbl_data
);

    import pkr_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    // Input stage: holds the pixel under lookup.
    pix_t  s1_reg;
    pix_t  s1_next;
    logic  s1_vld_reg;
    logic  s1_vld_next;
    logic  s1_adv;

    // Result stage.
    lbl_t  out_reg;
    lbl_t  out_next;
    logic  out_vld_reg;
    logic  out_vld_next;

    logic [2*BIN_BITS-1:0] key;
    lookup_t               lk;
    logic [IDX_W-1:0]      cam_label;
    logic [31:0]           label_wide;

    // Drop bin bits above BIN_BITS; bin_b lands in the upper half of the key.
    assign key = {s1_reg.bin_b[BIN_BITS-1:0], s1_reg.bin_a[BIN_BITS-1:0]};

    // Advance the pixel when the result register is free or being drained.
    assign s1_adv   = s1_vld_reg && (!out_vld_reg || lbl_ready);
    assign px_ready = !s1_vld_reg || s1_adv;

    pkr_cam #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .BIN_BITS    (BIN_BITS)
    ) u_cam (
        .clk    (clk),
        .rst_n  (rst_n),
        .key    (key),
        .clear  (s1_reg.first_pixel),
        .commit (s1_adv),
        .status (lk),
        .label  (cam_label)
    );

    // Widen the label to 32 bits; its low bits feed the output field.
    assign label_wide = 32'(cam_label);

    always_comb
    begin
        s1_vld_next = s1_vld_reg;
        s1_next     = s1_reg;
        if (px_ready)
        begin
            s1_vld_next = px_valid;
            s1_next     = px_data;
        end

        out_vld_next       = out_vld_reg;
        out_next           = out_reg;
        if (s1_adv)
        begin
            out_vld_next       = 1'b1;
            out_next.new_label = label_wide[LABEL_FIELD_W-1:0];
            out_next.is_new    = lk.fresh;
            out_next.overflow  = lk.full;
        end
        else if (lbl_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= s1_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        s1_reg  <= s1_next;
        out_reg <= out_next;
    end

    assign lbl_valid = out_vld_reg;
    assign lbl_data  = out_reg;

    // A result is never both a fresh entry and an overflow.
    `PKR_ASSERT_NOW(a_flags_exclusive, lbl_valid, !(lbl_data.is_new && lbl_data.overflow))
    // The first pixel of an image always gets label 0 as a new pair.
    `PKR_ASSERT_NEXT(a_first_pixel_label0, s1_adv && s1_reg.first_pixel,
        lbl_valid && lbl_data.is_new && (lbl_data.new_label == '0))
    // An empty result register never blocks the input side.
    `PKR_ASSERT_NOW(a_ready_when_drained, !lbl_valid, px_ready)

endmodule

`default_nettype wire

// ===== hdl/pkr_cam.sv =====
`default_nettype none

module pkr_cam #(
    parameter int TABLE_DEPTH = 256,
    parameter int BIN_BITS    = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [2*BIN_BITS-1:0]           key,
    input  logic                            clear,
    input  logic                            commit,
    output pkr_pkg::lookup_t                status,
    output logic [$clog2(TABLE_DEPTH)-1:0]  label
);

    import pkr_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W = 2 * BIN_BITS;

    logic [KEY_W-1:0]       keys_reg [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [TABLE_DEPTH-1:0] valid_next;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cnt_next;

    logic [TABLE_DEPTH-1:0] valid_eff;
    logic [CNT_W-1:0]       cnt_eff;
    logic [TABLE_DEPTH-1:0] match;
    logic [IDX_W-1:0]       hit_idx;
    logic [IDX_W-1:0]       wr_idx;
    logic                   hit;
    logic                   full;
    logic                   fresh;

    // Compare every live entry at once; stored keys are unique, so at most one matches.
    always_comb
    begin
        valid_eff = clear ? '0 : valid_reg;
        cnt_eff   = clear ? '0 : cnt_reg;
        hit_idx   = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            match[i] = valid_eff[i] && (keys_reg[i] == key);
            if (match[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
        hit    = |match;
        full   = !hit && (cnt_eff == CNT_W'(TABLE_DEPTH));
        fresh  = !hit && !full;
        wr_idx = cnt_eff[IDX_W-1:0];

        if (hit)
        begin
            label = hit_idx;
        end
        else if (fresh)
        begin
            label = wr_idx;
        end
        else
        begin
            label = '0;
        end

        status.hit   = hit;
        status.fresh = fresh;
        status.full  = full;

        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        if (commit)
        begin
            valid_next = valid_eff;
            cnt_next   = cnt_eff;
            if (fresh)
            begin
                valid_next[wr_idx] = 1'b1;
                cnt_next           = cnt_eff + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Store a new key at the next free label.
    always_ff @(posedge clk)
    begin
        if (commit && fresh)
        begin
            keys_reg[wr_idx] <= key;
        end
    end

endmodule

`default_nettype wire

// ===== bench/relabel_checker.sv =====
`default_nettype none

// Watches both channels, keeps its own pair table and checks every label in order.
module relabel_checker #(
    parameter int TABLE_DEPTH = 256,
    parameter int BIN_BITS    = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          px_valid,
    input  wire logic          px_ready,
    input  wire pkr_pkg::pix_t px_data,
    input  wire logic          lbl_valid,
    input  wire logic          lbl_ready,
    input  wire pkr_pkg::lbl_t lbl_data,
    output int                 errors,
    output int                 pending,
    output int                 checked,
    output int                 fresh_count,
    output int                 full_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import pkr_pkg::*;

    logic [31:0] pair_key_store [TABLE_DEPTH];
    logic        pair_key_live  [TABLE_DEPTH];
    int unsigned labels_issued;
    lbl_t        label_queue [$];
    int          err_n;
    int          checked_n;
    int          fresh_n;
    int          full_n;

    function automatic void empty_table();
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            pair_key_store[i] = '0;
            pair_key_live[i]  = 1'b0;
        end
        labels_issued = 0;
    endfunction

    // Look the pair up; store it under the next label on a miss.
    function automatic lbl_t assign_label(pix_t p);
        logic [15:0] bin_mask;
        logic [31:0] key;
        lbl_t        r;
        bit          hit;
        bin_mask = 16'((32'd1 << BIN_BITS) - 1);
        key      = {p.bin_b & bin_mask, p.bin_a & bin_mask};
        r        = '0;
        hit      = 1'b0;
        if (p.first_pixel)
            empty_table();
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (!hit && pair_key_live[i] && pair_key_store[i] == key)
            begin
                hit         = 1'b1;
                r.new_label = 8'(i);
            end
        end
        if (!hit)
        begin
            if (labels_issued < TABLE_DEPTH)
            begin
                r.new_label                   = 8'(labels_issued);
                pair_key_store[labels_issued] = key;
                pair_key_live[labels_issued]  = 1'b1;
                labels_issued++;
                r.is_new = 1'b1;
            end
            else
                r.overflow = 1'b1;
        end
        return r;
    endfunction

    function automatic void flag(string what, lbl_t want, lbl_t got);
        if (err_n < 10)
            $display("%0t: %s: expected label %0d new %0b ovf %0b, got label %0d new %0b ovf %0b",
                     $realtime, what, want.new_label, want.is_new, want.overflow,
                     got.new_label, got.is_new, got.overflow);
        err_n++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lbl_t want;
        if (!rst_n)
        begin
            empty_table();
            label_queue.delete();
        end
        else
        begin
            if (lbl_valid && lbl_ready)
            begin
                if (label_queue.size() == 0)
                    flag("result with no pixel waiting", '0, lbl_data);
                else
                begin
                    want = label_queue.pop_front();
                    checked_n++;
                    if (lbl_data.new_label !== want.new_label ||
                        lbl_data.is_new !== want.is_new ||
                        lbl_data.overflow !== want.overflow)
                        flag("label mismatch", want, lbl_data);
                end
            end
            if (px_valid && px_ready)
            begin
                want = assign_label(px_data);
                fresh_n += want.is_new;
                full_n  += want.overflow;
                label_queue.push_back(want);
            end
        end
        errors      <= err_n;
        pending     <= label_queue.size();
        checked     <= checked_n;
        fresh_count <= fresh_n;
        full_count  <= full_n;
    end

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pkr_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int BIN_BITS    = 16;
    localparam int PIXEL_GOAL  = 500;   // stop offering images once this many pixels went in
    localparam int QUIET_LIMIT = 2000;  // cycles with no transfer before the run is declared hung
    localparam int HOLD_CYCLES = 60;    // long receiver hold-off to back the block up

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic px_valid  = 1'b0;
    pix_t px_data   = '0;
    logic lbl_ready = 1'b0;
    logic px_ready;
    logic lbl_valid;
    lbl_t lbl_data;

    int errors;
    int pending;
    int checked;
    int fresh_count;
    int full_count;

    int pixels_sent = 0;
    int images      = 0;
    int quiet       = 0;
    bit tx_rush     = 1'b0;  // sender offers back to back while set
    bit rx_rush     = 1'b0;  // receiver never stalls while set

    always #5 clk = ~clk;

    pair_key_relabeler #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .BIN_BITS   (BIN_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .px_valid (px_valid),
        .px_ready (px_ready),
        .px_data  (px_data),
        .lbl_valid(lbl_valid),
        .lbl_ready(lbl_ready),
        .lbl_data (lbl_data)
    );

    relabel_checker #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .BIN_BITS   (BIN_BITS)
    ) relabel_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .px_valid   (px_valid),
        .px_ready   (px_ready),
        .px_data    (px_data),
        .lbl_valid  (lbl_valid),
        .lbl_ready  (lbl_ready),
        .lbl_data   (lbl_data),
        .errors     (errors),
        .pending    (pending),
        .checked    (checked),
        .fresh_count(fresh_count),
        .full_count (full_count)
    );

    // Offer one pixel after a random gap and hold it until the transfer.
    // Valid is only lowered when a gap follows, so a back-to-back pixel
    // never sees valid dropped and raised in the same step.
    task automatic send_pixel(input logic [15:0] a, input logic [15:0] b, input logic fp);
        int   gap;
        pix_t p;
        gap           = tx_rush ? 0 : $urandom_range(0, 9);
        p.bin_a       = a;
        p.bin_b       = b;
        p.first_pixel = fp;
        if (gap > 0)
        begin
            px_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        px_data  <= p;
        px_valid <= 1'b1;
        @(posedge clk);
        while (!px_ready)
            @(posedge clk);
        pixels_sent++;
    endtask

    // Drop valid and wait until every issued pixel has its label back.
    task automatic drain();
        px_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // One image drawn from a small palette, so most pixels hit a stored pair.
    // Now and then a stray first-pixel mark clears the table mid-image.
    task automatic send_image(input int len, input int colors);
        logic [15:0] pal_a [16];
        logic [15:0] pal_b [16];
        int          k;
        for (int i = 0; i < colors; i++)
        begin
            pal_a[i] = ($urandom_range(0, 7) == 0) ? 16'hffff : 16'($urandom);
            pal_b[i] = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom);
            // swapped pair: same bins, different key
            if (i > 0 && $urandom_range(0, 3) == 0)
            begin
                pal_a[i] = pal_b[i-1];
                pal_b[i] = pal_a[i-1];
            end
        end
        images++;
        for (int n = 0; n < len; n++)
        begin
            k = $urandom_range(0, colors - 1);
            send_pixel(pal_a[k], pal_b[k], n == 0 || $urandom_range(0, 39) == 0);
        end
    endtask

    // Fill every table entry, run two pixels into overflow, then mix hits
    // on stored pairs with more pairs that find the table full.
    task automatic fill_table();
        logic [15:0] seen_a [258];
        logic [15:0] seen_b [258];
        int          k;
        images++;
        for (int n = 0; n < 258; n++)
        begin
            seen_a[n] = 16'($urandom);
            seen_b[n] = 16'($urandom);
            send_pixel(seen_a[n], seen_b[n], n == 0);
        end
        for (int n = 0; n < 40; n++)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                k = $urandom_range(0, 257);
                send_pixel(seen_a[k], seen_b[k], 1'b0);
            end
            else
                send_pixel(16'($urandom), 16'($urandom), 1'b0);
        end
    endtask

    // Receiver: stall a random number of cycles before each result, with
    // stall-free stretches, and hold off for a long time twice so the
    // output and input registers fill and px_ready drops.
    initial
    begin
        int stall;
        int taken;
        taken = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (taken % 64 == 0)
                rx_rush = ($urandom_range(0, 2) == 0);
            stall = rx_rush ? 0 : $urandom_range(0, 9);
            if (taken == 60 || taken == 350)
                stall = HOLD_CYCLES;
            if (stall > 0)
            begin
                lbl_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            lbl_ready <= 1'b1;
            @(posedge clk);
            while (!lbl_valid)
                @(posedge clk);
            taken++;
        end
    end

    // Watchdog: end the run if no transfer happens on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (px_valid && px_ready) || (lbl_valid && lbl_ready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes of both bins, hits, key order, clears.
        send_pixel(16'h0000, 16'h0000, 1'b1);  // first pixel gets label 0
        send_pixel(16'h0000, 16'h0000, 1'b0);  // hit on label 0
        send_pixel(16'hffff, 16'hffff, 1'b0);
        send_pixel(16'hffff, 16'h0000, 1'b0);
        send_pixel(16'h0000, 16'hffff, 1'b0);
        send_pixel(16'h0001, 16'h0000, 1'b0);
        send_pixel(16'h0000, 16'h0001, 1'b0);  // swapped bins must not alias
        send_pixel(16'hffff, 16'hffff, 1'b0);  // hit on an older label
        send_pixel(16'haaaa, 16'h5555, 1'b0);
        send_pixel(16'h5555, 16'haaaa, 1'b0);
        send_pixel(16'h0000, 16'h0000, 1'b1);  // clear mid-stream, label 0 again
        send_pixel(16'hffff, 16'hffff, 1'b0);  // stored before the clear, new now
        send_pixel(16'h1234, 16'h5678, 1'b1);
        send_pixel(16'h1234, 16'h5678, 1'b1);  // repeated first pixel stays new
        send_pixel(16'h1234, 16'h5678, 1'b0);
        drain();

        // Random: short palette images, one full-table image, more images.
        while (pixels_sent < 120)
        begin
            tx_rush = ($urandom_range(0, 3) == 0);
            send_image($urandom_range(3, 30), $urandom_range(1, 12));
        end
        drain();
        tx_rush = 1'b0;
        fill_table();
        while (pixels_sent < PIXEL_GOAL)
        begin
            tx_rush = ($urandom_range(0, 3) == 0);
            send_image($urandom_range(3, 30), $urandom_range(1, 12));
            if ($urandom_range(0, 7) == 0)
                drain();
        end

        drain();
        repeat (5) @(posedge clk);

        $display("Covered %0d pixels in %0d images; %0d labels checked.",
                 pixels_sent, images, checked);
        $display("New pairs labeled %0d, table-full overflows %0d, mismatches %0d.",
                 fresh_count, full_count, errors);
        if (errors == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
